[rtl/core/assert_macros.svh]
// assertion macros used by the rtl line parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[rtl/core/hcl_pkg.sv]
// shared types and byte constants for the content-length extractor
`timescale 1ns / 1ps
package hcl_pkg;

  localparam logic [3:0] KEY_LEN = 4'd14;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_KEY0  = 8'h43;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               emit;
    logic               found;
    logic signed [31:0] length;
  } hcl_result_t;

  // characters of "Content-Length"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF;
  endfunction

endpackage

[rtl/core/hcl_line_parser.sv]
// per-line parser state: key match, number after colon, held length
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hcl_line_parser #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  output hcl_pkg::hcl_result_t res
);

  localparam int MagW = VALUE_BITS - 1;
  localparam logic [MagW+3:0] MagMax = (MagW + 4)'({MagW{1'b1}});

  logic [3:0]            pattern_progress, pattern_progress_next;
  logic                  pattern_seen, pattern_seen_next;
  logic                  colon_seen, colon_seen_next;
  hcl_pkg::phase_t       number_phase, number_phase_next;
  logic                  number_negative, number_negative_next;
  logic [MagW-1:0]       number_magnitude, number_magnitude_next;
  logic                  line_nonblank, line_nonblank_next;
  logic                  line_cut, line_cut_next;
  logic [VALUE_BITS-1:0] length_held, length_held_next;
  logic                  length_seen, length_seen_next;

  logic            is_nl;
  logic            is_digit;
  logic            body_byte;
  logic            num_byte;
  logic [MagW+3:0] mag_x10;
  logic [MagW-1:0] mag_add;
  logic [3:0]      key_next;

  assign is_nl     = data_byte == hcl_pkg::CH_NL;
  assign is_digit  = data_byte >= hcl_pkg::CH_ZERO && data_byte <= hcl_pkg::CH_NINE;
  assign body_byte = step && !is_nl && !line_cut && data_byte != hcl_pkg::CH_NUL;
  assign num_byte  = body_byte && colon_seen;

  // saturating multiply by ten plus digit
  assign mag_x10 = ({4'b0, number_magnitude} << 3) + ({4'b0, number_magnitude} << 1)
                 + (MagW + 4)'(data_byte[3:0]);
  assign mag_add = (mag_x10 > MagMax) ? MagMax[MagW-1:0] : mag_x10[MagW-1:0];

  // number phase
  always_comb begin
    number_phase_next = number_phase;
    if (step && is_nl) begin
      number_phase_next = hcl_pkg::PH_SKIP;
    end else if (num_byte) begin
      unique case (number_phase)
        hcl_pkg::PH_SKIP: begin
          if (hcl_pkg::is_blank(data_byte)) begin
            number_phase_next = hcl_pkg::PH_SKIP;
          end else if (data_byte == hcl_pkg::CH_PLUS || data_byte == hcl_pkg::CH_MINUS) begin
            number_phase_next = hcl_pkg::PH_SIGN;
          end else if (is_digit) begin
            number_phase_next = hcl_pkg::PH_DIGITS;
          end else begin
            number_phase_next = hcl_pkg::PH_DONE;
          end
        end
        hcl_pkg::PH_SIGN, hcl_pkg::PH_DIGITS: begin
          number_phase_next = is_digit ? hcl_pkg::PH_DIGITS : hcl_pkg::PH_DONE;
        end
        hcl_pkg::PH_DONE: number_phase_next = hcl_pkg::PH_DONE;
        default:          number_phase_next = hcl_pkg::PH_DONE;
      endcase
    end
  end

  // key match progress
  always_comb begin
    if (pattern_progress < hcl_pkg::KEY_LEN
        && data_byte == hcl_pkg::key_char(pattern_progress)) begin
      key_next = pattern_progress + 4'd1;
    end else begin
      key_next = (data_byte == hcl_pkg::CH_KEY0) ? 4'd1 : 4'd0;
    end
  end

  // everything else
  always_comb begin
    pattern_progress_next = pattern_progress;
    pattern_seen_next     = pattern_seen;
    colon_seen_next       = colon_seen;
    number_negative_next  = number_negative;
    number_magnitude_next = number_magnitude;
    line_nonblank_next    = line_nonblank;
    line_cut_next         = line_cut;
    length_held_next      = length_held;
    length_seen_next      = length_seen;
    if (step && is_nl) begin
      pattern_progress_next = '0;
      pattern_seen_next     = 1'b0;
      colon_seen_next       = 1'b0;
      number_negative_next  = 1'b0;
      number_magnitude_next = '0;
      line_nonblank_next    = 1'b0;
      line_cut_next         = 1'b0;
      if (!line_nonblank) begin
        length_held_next = '1;
        length_seen_next = 1'b0;
      end else if (pattern_seen) begin
        length_held_next = number_negative ? -{1'b0, number_magnitude}
                                           : {1'b0, number_magnitude};
        length_seen_next = 1'b1;
      end
    end else if (step && !line_cut && data_byte == hcl_pkg::CH_NUL) begin
      line_cut_next = 1'b1;
    end else if (body_byte) begin
      if (!hcl_pkg::is_blank(data_byte)) begin
        line_nonblank_next = 1'b1;
      end
      if (!pattern_seen) begin
        if (key_next == hcl_pkg::KEY_LEN) begin
          pattern_seen_next     = 1'b1;
          pattern_progress_next = '0;
        end else begin
          pattern_progress_next = key_next;
        end
      end
      if (colon_seen) begin
        if (number_phase == hcl_pkg::PH_SKIP
            && (data_byte == hcl_pkg::CH_PLUS || data_byte == hcl_pkg::CH_MINUS)) begin
          number_negative_next = data_byte == hcl_pkg::CH_MINUS;
        end
        if (number_phase != hcl_pkg::PH_DONE && is_digit) begin
          number_magnitude_next = mag_add;
        end
      end else if (data_byte == hcl_pkg::CH_COLON) begin
        colon_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_progress <= '0;
      pattern_seen     <= 1'b0;
      colon_seen       <= 1'b0;
      number_phase     <= hcl_pkg::PH_SKIP;
      number_negative  <= 1'b0;
      number_magnitude <= '0;
      line_nonblank    <= 1'b0;
      line_cut         <= 1'b0;
      length_held      <= '1;
      length_seen      <= 1'b0;
    end else begin
      pattern_progress <= pattern_progress_next;
      pattern_seen     <= pattern_seen_next;
      colon_seen       <= colon_seen_next;
      number_phase     <= number_phase_next;
      number_negative  <= number_negative_next;
      number_magnitude <= number_magnitude_next;
      line_nonblank    <= line_nonblank_next;
      line_cut         <= line_cut_next;
      length_held      <= length_held_next;
      length_seen      <= length_seen_next;
    end
  end

  assign res.emit   = is_nl && !line_nonblank;
  assign res.found  = length_seen;
  assign res.length = 32'(signed'(length_held));

  `ASSERT_NEXT(a_emit_clears, clk, rst, step && res.emit,
               !length_seen && length_held == '1 && !line_nonblank)
  `ASSERT_IMPLY(a_progress_range, clk, rst, 1'b1, pattern_progress < hcl_pkg::KEY_LEN)
  `ASSERT_IMPLY(a_seen_no_progress, clk, rst, pattern_seen, pattern_progress == '0)
  `ASSERT_IMPLY(a_phase_needs_colon, clk, rst, number_phase != hcl_pkg::PH_SKIP, colon_seen)

endmodule

[rtl/core/http_content_length_extractor.sv]
// top level of the http content-length extractor
//
//  port group  dir  payload
//  s_*         in   tdata[7:0] header byte
//  m_*         out  tdata[31:0] content length, tuser found flag
//
// one byte per cycle unless a stalled result blocks the input; each byte
// waits in the input register and updates the line state as it leaves it,
// at that same edge its result is registered in the output register
// a result is emitted only on a newline that ends a blank line
// synchronous active-high reset restores the held length to -1
// a stalled result only blocks the input when the next byte would emit too
`timescale 1ns / 1ps
module http_content_length_extractor #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // content_length
  output logic        m_tuser    // length_found
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;
  hcl_pkg::hcl_result_t res;

  assign advance  = in_valid && (!res.emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  hcl_line_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_tdata <= res.length;
      m_tuser <= res.found;
    end
  end

endmodule

[test/http_content_length_extractor_tb.sv]
// testbench for the content-length extractor: table-driven and random header blocks
`timescale 1ns / 1ps
module http_content_length_extractor_tb;

  localparam int LIMIT = 200000;
  localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;
  localparam logic [111:0] KEY_TEXT = "Content-Length";

  typedef struct packed {
    logic signed [31:0] len;
    logic               found;
  } length_rec_t;

  typedef struct {
    string              text;
    bit                 fixed;
    logic signed [31:0] len;
    logic               found;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // content_length
  logic        m_tuser;  // length_found

  // line state of the predictor
  logic [3:0]       key_pos;
  logic             key_hit;
  logic             colon_hit;
  hcl_pkg::phase_t  num_phase;
  logic             num_neg;
  logic [31:0]      num_mag;
  logic             line_text;
  logic             line_cut;
  logic [31:0]      held_len;
  logic             held_found;

  length_rec_t pending_lengths[$];
  length_rec_t head_rec;
  logic [7:0]  blk[$];
  int          bytes_sent = 0;
  int          results_due = 0;
  int          results_seen = 0;
  int          found_seen = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          rx_count = 0;
  logic [1:0]  rx_mode = 2'd0;
  logic [4:0]  rx_phase = 5'd0;

  // '^' stands for a NUL byte
  row_t dir_rows [11] = '{
    '{"\n", 1'b1, -32'sd1, 1'b0},
    '{"Content-Length: 99999999999\n\n", 1'b1, 32'sd2147483647, 1'b1},
    '{"Content-Length:-99999999999\015\n\015\n", 1'b1, -32'sd2147483647, 1'b1},
    '{"Content-Length\n \t\n", 1'b1, 32'sd0, 1'b1},
    '{"Host: x\nContent-Type: text\n\n", 1'b1, -32'sd1, 1'b0},
    '{":+42 Content-Length\n\n", 1'b0, 32'sd0, 1'b0},
    '{"ConContent-Length:\013\014 007\n\n", 1'b0, 32'sd0, 1'b0},
    '{"Content-Length: 5^Content-Length: 9\n^Content-Length: 3\n", 1'b0, 32'sd0, 1'b0},
    '{"Content-Length: 3\nX-Content-Length: -8x\n\n", 1'b0, 32'sd0, 1'b0},
    '{"\377\200:12\n\t\n", 1'b0, 32'sd0, 1'b0},
    '{"Content-Length: -0\n\n", 1'b0, 32'sd0, 1'b0}
  };

  http_content_length_extractor #(
    .VALUE_BITS(32)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic is_space_byte(input logic [7:0] b);
    return b == hcl_pkg::CH_SP || b == hcl_pkg::CH_TAB || b == hcl_pkg::CH_CR
        || b == hcl_pkg::CH_VT || b == hcl_pkg::CH_FF;
  endfunction

  task automatic start_line();
    key_pos = 4'd0;
    key_hit = 1'b0;
    colon_hit = 1'b0;
    num_phase = hcl_pkg::PH_SKIP;
    num_neg = 1'b0;
    num_mag = 32'd0;
    line_text = 1'b0;
    line_cut = 1'b0;
  endtask

  task automatic push_digit(input logic [7:0] b);
    logic [31:0] d;
    d = b - hcl_pkg::CH_ZERO;
    if (num_mag > (MAG_MAX - d) / 10) begin
      num_mag = MAG_MAX;
    end else begin
      num_mag = num_mag * 10 + d;
    end
  endtask

  task automatic scan_value(input logic [7:0] b);
    logic digit;
    digit = b >= hcl_pkg::CH_ZERO && b <= hcl_pkg::CH_NINE;
    case (num_phase)
      hcl_pkg::PH_SKIP: begin
        if (is_space_byte(b)) begin
        end else if (b == hcl_pkg::CH_PLUS || b == hcl_pkg::CH_MINUS) begin
          num_neg = b == hcl_pkg::CH_MINUS;
          num_phase = hcl_pkg::PH_SIGN;
        end else if (digit) begin
          push_digit(b);
          num_phase = hcl_pkg::PH_DIGITS;
        end else begin
          num_phase = hcl_pkg::PH_DONE;
        end
      end
      hcl_pkg::PH_SIGN, hcl_pkg::PH_DIGITS: begin
        if (digit) begin
          push_digit(b);
          num_phase = hcl_pkg::PH_DIGITS;
        end else begin
          num_phase = hcl_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic track_header_byte(input logic [7:0] b, output bit fired,
                                   output length_rec_t rec);
    logic [3:0] p;
    fired = 1'b0;
    rec = '{len: held_len, found: held_found};
    if (b == hcl_pkg::CH_NL) begin
      if (!line_text) begin
        fired = 1'b1;
        held_len = '1;
        held_found = 1'b0;
      end else if (key_hit) begin
        held_len = num_neg ? -num_mag : num_mag;
        held_found = 1'b1;
      end
      start_line();
    end else if (!line_cut) begin
      if (b == hcl_pkg::CH_NUL) begin
        line_cut = 1'b1;
      end else begin
        if (!is_space_byte(b)) line_text = 1'b1;
        if (!key_hit) begin
          p = key_pos;
          if (p < hcl_pkg::KEY_LEN && b == KEY_TEXT[111 - 8 * p -: 8]) begin
            p = p + 4'd1;
          end else begin
            p = (b == hcl_pkg::CH_KEY0) ? 4'd1 : 4'd0;
          end
          if (p >= hcl_pkg::KEY_LEN) begin
            key_hit = 1'b1;
            p = 4'd0;
          end
          key_pos = p;
        end
        if (colon_hit) begin
          scan_value(b);
        end else if (b == hcl_pkg::CH_COLON) begin
          colon_hit = 1'b1;
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed_on,
                           input length_rec_t typed_rec);
    int gap;
    bit fired;
    length_rec_t rec;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    track_header_byte(b, fired, rec);
    if (fired) begin
      pending_lengths.push_back(typed_on ? typed_rec : rec);
      results_due++;
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) blk.push_back(s[i]);
  endtask

  task automatic put_space();
    case ($urandom_range(0, 4))
      0: blk.push_back(hcl_pkg::CH_SP);
      1: blk.push_back(hcl_pkg::CH_TAB);
      2: blk.push_back(hcl_pkg::CH_CR);
      3: blk.push_back(hcl_pkg::CH_VT);
      default: blk.push_back(hcl_pkg::CH_FF);
    endcase
  endtask

  task automatic put_value();
    int n;
    repeat ($urandom_range(0, 3)) put_space();
    case ($urandom_range(0, 5))
      0: blk.push_back(hcl_pkg::CH_MINUS);
      1: blk.push_back(hcl_pkg::CH_PLUS);
      default: begin
      end
    endcase
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
    repeat (n) blk.push_back(hcl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) put_text(" ;q=1");
  endtask

  task automatic put_key_line();
    case ($urandom_range(0, 4))
      0: put_text("X-");
      1: put_text("Con");
      2: put_text("Content-Len");
      default: begin
      end
    endcase
    put_text("Content-Length");
    if ($urandom_range(0, 3) == 0) put_space();
    if ($urandom_range(0, 7) != 0) blk.push_back(hcl_pkg::CH_COLON);
    put_value();
  endtask

  task automatic put_line_end();
    if ($urandom_range(0, 1) == 0) blk.push_back(hcl_pkg::CH_CR);
    blk.push_back(hcl_pkg::CH_NL);
  endtask

  // mostly well-formed header blocks with random content, some noise
  task automatic build_block();
    int ls;
    blk.delete();
    repeat ($urandom_range(0, 3)) begin
      ls = blk.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: put_key_line();
        4, 5: begin
          repeat ($urandom_range(1, 8)) blk.push_back(8'h61 + 8'($urandom_range(0, 25)));
          put_text(": ");
          repeat ($urandom_range(0, 12)) blk.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        6: begin
          blk.push_back(hcl_pkg::CH_COLON);
          put_value();
          put_text(" Content-Length");
        end
        7: begin
          put_key_line();
          blk.insert($urandom_range(ls, blk.size()), hcl_pkg::CH_NUL);
        end
        8: repeat ($urandom_range(1, 10)) blk.push_back(8'($urandom_range(0, 255)));
        default: begin
          put_text("Content-Length: ");
          put_value();
        end
      endcase
      put_line_end();
    end
    case ($urandom_range(0, 4))
      0: blk.push_back(hcl_pkg::CH_NL);
      1: put_text("\015\n");
      2: put_text(" \t\n");
      3: begin
        blk.push_back(hcl_pkg::CH_NUL);
        repeat ($urandom_range(0, 5)) blk.push_back(8'($urandom_range(1, 255)));
        blk.push_back(hcl_pkg::CH_NL);
      end
      default: put_text("\013\014\n");
    endcase
  endtask

  // receiver stall pattern, switching between modes
  always @(negedge clk) begin
    if (rx_count == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_count <= $urandom_range(20, 80);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= rx_phase[1:0] == 2'd0;
      default: m_tready <= rx_phase > 5'd18;
    endcase
    rx_phase <= rx_phase + 5'd1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lengths.size() == 0) begin
        $error("unexpected result: content_length %0d, length_found %0b",
               $signed(m_tdata), m_tuser);
        fail_count++;
      end else begin
        head_rec = pending_lengths.pop_front();
        results_seen++;
        if (m_tuser) found_seen++;
        if (m_tdata !== head_rec.len) begin
          $error("content_length: expected %0d, actual %0d", head_rec.len, $signed(m_tdata));
          fail_count++;
        end
        if (m_tuser !== head_rec.found) begin
          $error("length_found: expected %0b, actual %0b", head_rec.found, m_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("http_content_length_extractor test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] c;
    length_rec_t typed;
    length_rec_t none;
    none = '{len: '0, found: 1'b0};
    start_line();
    held_len = '1;
    held_found = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      typed = '{len: dir_rows[r].len, found: dir_rows[r].found};
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        c = dir_rows[r].text[i];
        if (c == "^") c = hcl_pkg::CH_NUL;
        send_byte(c, dir_rows[r].fixed, typed);
      end
    end
    wait_idle();

    while (bytes_sent < 800) begin
      build_block();
      if ($urandom_range(0, 11) == 0) wait_idle();
      foreach (blk[i]) send_byte(blk[i], 1'b0, none);
    end

    s_tvalid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("sent %0d header bytes (table rows, then random header blocks with noise)",
             bytes_sent);
    $display("checked %0d of %0d length results, %0d of them with a length found",
             results_seen, results_due, found_seen);
    if (fail_count == 0) begin
      $display("http_content_length_extractor test passed");
    end else begin
      $display("http_content_length_extractor test failed");
    end
    $finish;
  end

endmodule
